>>> rtl/b64d_pkg.sv
package b64d_pkg;

   localparam int MAX_RSP   = 4;
   localparam int RSP_DEPTH = 8;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int CNT_W     = $clog2(RSP_DEPTH + 1);
   localparam int NUM_W     = $clog2(MAX_RSP + 1);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR = 2'd1;
   localparam logic [1:0] ST_BAD_PAD  = 2'd2;
   localparam logic [1:0] ST_BAD_LEN  = 2'd3;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_DIG_0 = 8'h30;
   localparam logic [7:0] CHAR_DIG_9 = 8'h39;

   typedef struct packed {
      logic [7:0] char_in;
      logic       msg_last;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       is_end;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_RSP-1:0] item;
      logic [NUM_W-1:0]      num;
   } bundle_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
   endfunction

   // {in alphabet, sextet}
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         t = c - CHAR_UC_A;
         return {1'b1, t[5:0]};
      end
      if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         t = c - CHAR_LC_A + 8'd26;
         return {1'b1, t[5:0]};
      end
      if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
         t = c - CHAR_DIG_0 + 8'd52;
         return {1'b1, t[5:0]};
      end
      if (c == CHAR_PLUS) begin
         return {1'b1, 6'd62};
      end
      if (c == CHAR_SLASH) begin
         return {1'b1, 6'd63};
      end
      return 7'd0;
   endfunction

endpackage

>>> rtl/b64d_core.sv
module b64d_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  b64d_pkg::req_type   req,
   output b64d_pkg::bundle_type bundle
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] held_ff, held_in;
   logic        third_ff, third_in;
   logic        pc_ff, pc_in;
   logic        any_ff, any_in;
   logic [1:0]  err_ff, err_in;

   logic [6:0]  sx;
   logic [5:0]  v, d, a, b, s3;
   logic        pad, ok, kept;
   logic [7:0]  b0, b1, b2;
   logic        e0, e1, e2;
   logic [1:0]  st;

   always_comb begin
      sx   = b64d_pkg::sextet_of(req.char_in);
      ok   = sx[6];
      v    = sx[5:0];
      pad  = req.char_in == b64d_pkg::CHAR_PAD;
      kept = !b64d_pkg::is_blank(req.char_in);
      d    = pad ? 6'd0 : v;
      a    = held_ff[17:12];
      b    = held_ff[11:6];
      s3   = held_ff[5:0];
      b0   = {a, b[5:4]};
      b1   = {b[3:0], s3[5:2]};
      b2   = {s3[1:0], d};
      e0   = 1'b0;
      e1   = 1'b0;
      e2   = 1'b0;

      pos_in   = pos_ff;
      held_in  = held_ff;
      third_in = third_ff;
      pc_in    = pc_ff;
      any_in   = any_ff;
      err_in   = err_ff;

      if (kept) begin
         any_in = 1'b1;
         if (err_ff == b64d_pkg::ST_OK) begin
            if (pc_ff) begin
               err_in = b64d_pkg::ST_BAD_PAD;
            end else if (!pad && !ok) begin
               err_in = b64d_pkg::ST_BAD_CHAR;
            end else begin
               case (pos_ff)
                  2'd0, 2'd1: begin
                     if (pad) begin
                        err_in = b64d_pkg::ST_BAD_PAD;
                     end else begin
                        held_in = {held_ff[11:0], v};
                        pos_in  = pos_ff + 2'd1;
                     end
                  end
                  2'd2: begin
                     third_in = pad;
                     held_in  = {held_ff[11:0], d};
                     pos_in   = 2'd3;
                  end
                  default: begin
                     if (third_ff && !pad) begin
                        err_in = b64d_pkg::ST_BAD_PAD;
                     end else begin
                        e0       = 1'b1;
                        e1       = !third_ff;
                        e2       = !pad;
                        pc_in    = pad;
                        pos_in   = 2'd0;
                        held_in  = 18'd0;
                        third_in = 1'b0;
                     end
                  end
               endcase
            end
         end
      end

      st = err_in;
      if (st == b64d_pkg::ST_OK && (!any_in || pos_in != 2'd0)) begin
         st = b64d_pkg::ST_BAD_LEN;
      end

      // pack the results in order
      bundle = '0;
      if (e0) begin
         bundle.item[bundle.num[1:0]] = '{byte_out: b0, is_end: 1'b0,
                                          status: b64d_pkg::ST_OK};
         bundle.num = bundle.num + 1'b1;
      end
      if (e1) begin
         bundle.item[bundle.num[1:0]] = '{byte_out: b1, is_end: 1'b0,
                                          status: b64d_pkg::ST_OK};
         bundle.num = bundle.num + 1'b1;
      end
      if (e2) begin
         bundle.item[bundle.num[1:0]] = '{byte_out: b2, is_end: 1'b0,
                                          status: b64d_pkg::ST_OK};
         bundle.num = bundle.num + 1'b1;
      end
      if (req.msg_last) begin
         bundle.item[bundle.num[1:0]] = '{byte_out: 8'd0, is_end: 1'b1, status: st};
         bundle.num = bundle.num + 1'b1;
         pos_in   = 2'd0;
         held_in  = 18'd0;
         third_in = 1'b0;
         pc_in    = 1'b0;
         any_in   = 1'b0;
         err_in   = b64d_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         held_ff  <= 18'd0;
         third_ff <= 1'b0;
         pc_ff    <= 1'b0;
         any_ff   <= 1'b0;
         err_ff   <= b64d_pkg::ST_OK;
      end else if (fire) begin
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         third_ff <= third_in;
         pc_ff    <= pc_in;
         any_ff   <= any_in;
         err_ff   <= err_in;
      end
   end

endmodule

>>> rtl/b64d_rsp_fifo.sv
module b64d_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  b64d_pkg::bundle_type           bundle,
   input  logic                           pop,
   output logic [b64d_pkg::CNT_W-1:0]     count,
   output b64d_pkg::rsp_type              head
);

   b64d_pkg::rsp_type                   mem_ff [b64d_pkg::RSP_DEPTH];
   logic [b64d_pkg::PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [b64d_pkg::NUM_W-1:0]          num;

   always_comb begin
      num       = push ? bundle.num : '0;
      wr_ptr_in = wr_ptr_ff + b64d_pkg::PTR_W'(num);
      rd_ptr_in = rd_ptr_ff + b64d_pkg::PTR_W'(pop);
      count_in  = count_ff + b64d_pkg::CNT_W'(num) - b64d_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < b64d_pkg::MAX_RSP; k++) begin
         if (b64d_pkg::NUM_W'(k) < num) begin
            mem_ff[wr_ptr_ff + b64d_pkg::PTR_W'(k)] <= bundle.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign count = count_ff;
   assign head  = mem_ff[rd_ptr_ff];

endmodule

>>> rtl/base64_stream_decoder.sv
// channel   direction  payload                          handshake
// req_      in         char_in, msg_last                 req_valid / req_ready
// rsp_      out        byte_out, is_end, status          rsp_valid / rsp_ready
//
// one character a cycle while no stall: a request is registered, then decoded
// and its zero to four responses are queued in an eight-entry response queue
// requests stall only while the queue has fewer than four free entries
// first response of a request is valid after the request register and the queue
// synchronous active-high reset empties the queue and clears the group state
module base64_stream_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  b64d_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output b64d_pkg::rsp_type    rsp_data
);

   logic                        in_valid_ff, in_valid_in;
   b64d_pkg::req_type           in_data_ff;
   logic                        fire;
   logic                        pop;
   logic [b64d_pkg::CNT_W-1:0]  count;
   b64d_pkg::bundle_type        bundle;
   logic [1:0]                  last_slot;

   assign fire      = in_valid_ff
                      && count <= b64d_pkg::CNT_W'(b64d_pkg::RSP_DEPTH - b64d_pkg::MAX_RSP);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = count != '0;
   assign pop       = rsp_valid && rsp_ready;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);
   assign last_slot = bundle.num[1:0] - 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   b64d_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .req    (in_data_ff),
      .bundle (bundle)
   );

   b64d_rsp_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (fire),
      .bundle (bundle),
      .pop    (pop),
      .count  (count),
      .head   (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count <= b64d_pkg::CNT_W'(b64d_pkg::RSP_DEPTH))
      else $error("response queue overflow");

   a_last_gives_status: assert property (@(posedge clock) disable iff (reset)
      fire && in_data_ff.msg_last |-> bundle.num != '0
         && bundle.item[last_slot].is_end)
      else $error("end of message without status response");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_end |-> rsp_data.status == b64d_pkg::ST_OK)
      else $error("byte response with nonzero status");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !fire && !pop |=> $stable(count))
      else $error("queue count moved without push or pop");

endmodule

>>> test/base64_stream_decoder_test.sv
module base64_stream_decoder_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   b64d_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   b64d_pkg::rsp_type rsp_data;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   // decoder state mirrored on the test side
   logic [1:0]  grp_pos = '0;
   logic [17:0] held_bits = '0;
   logic        third_pad = 1'b0;
   logic        pad_closed = 1'b0;
   logic        seen_any = 1'b0;
   logic [1:0]  err_code = b64d_pkg::ST_OK;

   b64d_pkg::rsp_type decoded_q[$];
   logic [7:0]        msg_buf[$];

   base64_stream_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic b64d_pkg::rsp_type make_rsp(input logic [7:0] value,
                                                  input logic end_flag,
                                                  input logic [1:0] st);
      b64d_pkg::rsp_type r;
      r.byte_out = value;
      r.is_end   = end_flag;
      r.status   = st;
      return r;
   endfunction

   task automatic queue_rsp(input logic [7:0] value, input logic end_flag,
                            input logic [1:0] st);
      decoded_q.insert(decoded_q.size(), make_rsp(value, end_flag, st));
   endtask

   task automatic buf_add(input logic [7:0] c);
      msg_buf.insert(msg_buf.size(), c);
   endtask

   // -1 when the character is outside the alphabet
   function automatic int sextet_value(input logic [7:0] c);
      if (c >= b64d_pkg::CHAR_UC_A && c <= b64d_pkg::CHAR_UC_Z)
         return int'(c) - int'(b64d_pkg::CHAR_UC_A);
      if (c >= b64d_pkg::CHAR_LC_A && c <= b64d_pkg::CHAR_LC_Z)
         return int'(c) - int'(b64d_pkg::CHAR_LC_A) + 26;
      if (c >= b64d_pkg::CHAR_DIG_0 && c <= b64d_pkg::CHAR_DIG_9)
         return int'(c) - int'(b64d_pkg::CHAR_DIG_0) + 52;
      if (c == b64d_pkg::CHAR_PLUS) return 62;
      if (c == b64d_pkg::CHAR_SLASH) return 63;
      return -1;
   endfunction

   function automatic logic [7:0] alpha_char(input int v);
      if (v < 26) return b64d_pkg::CHAR_UC_A + 8'(v);
      if (v < 52) return b64d_pkg::CHAR_LC_A + 8'(v - 26);
      if (v < 62) return b64d_pkg::CHAR_DIG_0 + 8'(v - 52);
      if (v == 62) return b64d_pkg::CHAR_PLUS;
      return b64d_pkg::CHAR_SLASH;
   endfunction

   function automatic logic [7:0] space_char();
      if ($urandom_range(5) == 5) return b64d_pkg::CHAR_SPACE;
      return b64d_pkg::CHAR_TAB + 8'($urandom_range(4));
   endfunction

   task automatic decode_char(input logic [7:0] c, input logic end_flag);
      int         sv;
      logic       is_pad;
      logic       blank;
      logic [5:0] v;
      logic [5:0] a;
      logic [5:0] b;
      logic [5:0] s3;
      logic [1:0] st;
      blank = (c >= b64d_pkg::CHAR_TAB && c <= b64d_pkg::CHAR_CR)
              || c == b64d_pkg::CHAR_SPACE;
      if (!blank) begin
         is_pad = (c == b64d_pkg::CHAR_PAD);
         sv = sextet_value(c);
         v = (sv < 0 || is_pad) ? 6'd0 : 6'(sv);
         seen_any = 1'b1;
         if (err_code == b64d_pkg::ST_OK) begin
            if (pad_closed) begin
               err_code = b64d_pkg::ST_BAD_PAD;
            end else if (!is_pad && sv < 0) begin
               err_code = b64d_pkg::ST_BAD_CHAR;
            end else begin
               case (grp_pos)
                  2'd0, 2'd1: begin
                     if (is_pad) begin
                        err_code = b64d_pkg::ST_BAD_PAD;
                     end else begin
                        held_bits = {held_bits[11:0], v};
                        grp_pos = grp_pos + 2'd1;
                     end
                  end
                  2'd2: begin
                     third_pad = is_pad;
                     held_bits = {held_bits[11:0], v};
                     grp_pos = 2'd3;
                  end
                  default: begin
                     a  = held_bits[17:12];
                     b  = held_bits[11:6];
                     s3 = held_bits[5:0];
                     if (third_pad && !is_pad) begin
                        err_code = b64d_pkg::ST_BAD_PAD;
                     end else begin
                        queue_rsp({a, b[5:4]}, 1'b0, b64d_pkg::ST_OK);
                        if (!third_pad)
                           queue_rsp({b[3:0], s3[5:2]}, 1'b0, b64d_pkg::ST_OK);
                        if (!is_pad)
                           queue_rsp({s3[1:0], v}, 1'b0, b64d_pkg::ST_OK);
                        if (is_pad)
                           pad_closed = 1'b1;
                        grp_pos = 2'd0;
                        held_bits = '0;
                        third_pad = 1'b0;
                     end
                  end
               endcase
            end
         end
      end
      if (end_flag) begin
         st = err_code;
         if (st == b64d_pkg::ST_OK && (!seen_any || grp_pos != 2'd0))
            st = b64d_pkg::ST_BAD_LEN;
         queue_rsp(8'd0, 1'b1, st);
         grp_pos = '0;
         held_bits = '0;
         third_pad = 1'b0;
         pad_closed = 1'b0;
         seen_any = 1'b0;
         err_code = b64d_pkg::ST_OK;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   always @(posedge clock) begin
      b64d_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("response with none pending, byte_out", rsp_data.byte_out, 0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_data.byte_out !== want.byte_out)
               report_mismatch("byte_out", rsp_data.byte_out, want.byte_out);
            if (rsp_data.is_end !== want.is_end)
               report_mismatch("is_end", rsp_data.is_end, want.is_end);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
         end
      end
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_char(input logic [7:0] c, input logic end_flag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.char_in = c;
      req_data.msg_last = end_flag;
      do begin
         @(posedge clock);
      end while (!req_ready);
      decode_char(c, end_flag);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic end_flag);
      for (int k = 0; k < s.len(); k++)
         send_char(s[k], end_flag && (k == s.len() - 1));
   endtask

   task automatic send_msg_buf();
      for (int k = 0; k < msg_buf.size(); k++)
         send_char(msg_buf[k], k == msg_buf.size() - 1);
   endtask

   task automatic push_alpha(input logic [7:0] c);
      if ($urandom_range(9) == 0)
         buf_add(space_char());
      buf_add(c);
   endtask

   task automatic build_wellformed_msg();
      int n_groups;
      int n_pad;
      n_groups = $urandom_range(1, 4);
      msg_buf.delete();
      for (int g = 0; g < n_groups; g++) begin
         n_pad = (g == n_groups - 1) ? $urandom_range(0, 2) : 0;
         for (int k = 0; k < 4; k++)
            push_alpha((k >= 4 - n_pad) ? b64d_pkg::CHAR_PAD
                                        : alpha_char($urandom_range(63)));
      end
      if ($urandom_range(4) == 0)
         buf_add(space_char());
   endtask

   task automatic test_directed();
      send_text("TWFu", 1'b1);
      send_text("/+9=", 1'b0);
      send_char(b64d_pkg::CHAR_CR, 1'b1);
      // empty message
      send_char(b64d_pkg::CHAR_TAB, 1'b1);
      // pad in second position
      send_text("A=", 1'b1);
      // third pad followed by a data character
      send_text("AB=A", 1'b1);
      // third pad followed by a character outside the alphabet
      send_text("zZ=", 1'b0);
      send_char(8'hFF, 1'b1);
      // data after a padded group, after its byte is out
      send_text("AA==9", 1'b1);
      send_char(8'hFF, 1'b1);
      // incomplete group
      send_text("ab", 1'b1);
   endtask

   task automatic test_wellformed_msgs(input int n_items);
      int start;
      start = items_sent;
      while (items_sent - start < n_items) begin
         build_wellformed_msg();
         send_msg_buf();
      end
   endtask

   task automatic test_broken_msgs(input int n_items);
      int start;
      int n_more;
      start = items_sent;
      while (items_sent - start < n_items) begin
         build_wellformed_msg();
         case ($urandom_range(3))
            0: msg_buf[$urandom_range(msg_buf.size() - 1)] = 8'($urandom_range(255));
            1: msg_buf.delete($urandom_range(msg_buf.size() - 1));
            2: msg_buf.insert($urandom_range(msg_buf.size()), b64d_pkg::CHAR_PAD);
            default: begin
               buf_add(alpha_char($urandom_range(63)));
               buf_add(alpha_char($urandom_range(63)));
               buf_add(b64d_pkg::CHAR_PAD);
               buf_add(b64d_pkg::CHAR_PAD);
               n_more = $urandom_range(1, 4);
               for (int k = 0; k < n_more; k++)
                  buf_add(alpha_char($urandom_range(63)));
            end
         endcase
         send_msg_buf();
      end
   endtask

   task automatic test_noise(input int n_items);
      for (int k = 0; k < n_items; k++)
         send_char(8'($urandom_range(255)), ($urandom_range(7) == 0) || (k == n_items - 1));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0)
            test_directed();
         test_wellformed_msgs(90);
         test_broken_msgs(25);
         test_noise(15);
      end
      req_valid = 1'b0;
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
